// ===== hdl/ordered_array_table_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array table engine
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OATE_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OATE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/oate_pkg.sv =====
// ----------------------------------------------------------------------------
// oate_pkg
// Widths, opcodes and status codes of the ordered array table engine.
// ----------------------------------------------------------------------------
package oate_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int POS_W     = 5;
	localparam int ST_W      = 3;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int MAX_RES   = 16;

	typedef logic [OP_W-1:0] opcode_t;
	typedef logic [ST_W-1:0] status_t;

	localparam opcode_t OP_CLEAR   = 3'd0;
	localparam opcode_t OP_APPEND  = 3'd1;
	localparam opcode_t OP_SEARCH  = 3'd2;
	localparam opcode_t OP_INSERT  = 3'd3;
	localparam opcode_t OP_DEL_POS = 3'd4;
	localparam opcode_t OP_DEL_VAL = 3'd5;

	localparam status_t ST_DONE      = 3'd0;
	localparam status_t ST_FOUND     = 3'd1;
	localparam status_t ST_NOT_FOUND = 3'd2;
	localparam status_t ST_INVALID   = 3'd3;
	localparam status_t ST_FULL      = 3'd4;

endpackage

// ===== hdl/oate_ifs.sv =====
// ----------------------------------------------------------------------------
// oate channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface oate_cmd_if import oate_pkg::*;;
	logic                     valid;
	logic                     ready;
	opcode_t                  opcode;
	logic signed [DATA_W-1:0] data_value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output opcode, output data_value, output position,
		input ready);
	modport sink (input valid, input opcode, input data_value, input position,
		output ready);
endinterface

interface oate_res_if import oate_pkg::*;;
	logic             valid;
	logic             ready;
	status_t          status;
	logic [IDX_W-1:0] match_index;
	logic [CNT_W-1:0] fill_count;
	logic             last;

	modport source (output valid, output status, output match_index, output fill_count,
		output last, input ready);
	modport sink (input valid, input status, input match_index, input fill_count,
		input last, output ready);
endinterface

// ===== hdl/ordered_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// Dense array of signed 32-bit entries with clear, append, search, insert
// and delete commands, run by a small sequencer over one memory with separate read and write ports.
// ----------------------------------------------------------------------------
// The engine takes one command word at a time and is not ready again until
// its last result word has been loaded into the output register. Clear,
// append and rejected commands go from the start state straight to the emit
// state. Search and delete by value read each entry from memory, then compare
// it. Insert and delete at a position move each entry through the memory's
// read and write ports, a read state then a write state per entry. A waiting
// result word holds the sequencer only when it has a further word to emit.
module ordered_array_table_engine import oate_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	oate_cmd_if.sink  cmd,
	oate_res_if.source res
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int AW   = $clog2(DEPTH);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [3:0]    LAST_PAIR = 4'(MAX_RES - 2);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_START   = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_SCMP    = 4'd3;
	localparam logic [3:0] S_FINAL   = 4'd4;
	localparam logic [3:0] S_SHDN_RD = 4'd5;
	localparam logic [3:0] S_SHDN_WR = 4'd6;
	localparam logic [3:0] S_SHUP_RD = 4'd7;
	localparam logic [3:0] S_SHUP_WR = 4'd8;
	localparam logic [3:0] S_EMIT    = 4'd9;

	logic [3:0]        state_q;
	opcode_t           op_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	status_t           res_st_q;
	logic              pend_q;
	logic [CW-1:0]     pend_idx_q;
	logic [3:0]        emit_cnt_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_last_q;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;

	logic              out_free;
	logic              match;
	logic              emit_req;
	status_t           emit_status;
	logic [CW-1:0]     emit_idx;
	logic              emit_last;

	assign cmd.ready       = (state_q == S_IDLE);
	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.match_index = out_index_q;
	assign res.fill_count  = out_count_q;
	assign res.last        = out_last_q;

	assign out_free = !out_valid_q || res.ready;
	assign match    = (rd_data_q == val_q);

	// Memory port control.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(idx_q);
		wr_data = rd_data_q;
		rd_addr = AW'(idx_q);
		case (state_q)
			S_START: begin
				if (op_q == OP_APPEND && count_q != DEPTH_C) begin
					wr_en   = 1'b1;
					wr_addr = AW'(count_q);
					wr_data = val_q;
				end
			end
			S_SHDN_RD: begin
				rd_addr = AW'(idx_q + CW'(1));
			end
			S_SHDN_WR: begin
				wr_en = 1'b1;
			end
			S_SHUP_RD: begin
				rd_addr = AW'(idx_q - CW'(1));
				// Once the gap has reached the target position, drop the new word in.
				if (!(CMPW'(idx_q) > CMPW'(pos_q))) begin
					wr_en   = 1'b1;
					wr_data = val_q;
				end
			end
			S_SHUP_WR: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Result word selection.
	always_comb begin
		emit_req    = 1'b0;
		emit_status = ST_DONE;
		emit_idx    = '0;
		emit_last   = 1'b1;
		case (state_q)
			S_SCMP: begin
				// A search match pushes out the one held before it.
				emit_req    = (op_q == OP_SEARCH) && match && pend_q;
				emit_status = ST_FOUND;
				emit_idx    = pend_idx_q;
				emit_last   = 1'b0;
			end
			S_FINAL: begin
				emit_req    = 1'b1;
				emit_status = pend_q ? ST_FOUND : ST_NOT_FOUND;
				emit_idx    = pend_q ? pend_idx_q : '0;
			end
			S_EMIT: begin
				emit_req    = 1'b1;
				emit_status = res_st_q;
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_CLEAR;
			val_q        <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			res_st_q     <= ST_DONE;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			emit_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_DONE;
			out_index_q  <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_req && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= emit_status;
				out_index_q  <= IDX_W'(emit_idx);
				out_count_q  <= CNT_W'(count_q);
				out_last_q   <= emit_last;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.opcode;
						val_q   <= cmd.data_value;
						pos_q   <= cmd.position;
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_EMIT;
					case (op_q)
						OP_CLEAR: begin
							count_q  <= '0;
							res_st_q <= ST_DONE;
						end
						OP_APPEND: begin
							if (count_q == DEPTH_C) begin
								res_st_q <= ST_FULL;
							end else begin
								count_q  <= count_q + CW'(1);
								res_st_q <= ST_DONE;
							end
						end
						OP_SEARCH, OP_DEL_VAL: begin
							idx_q      <= '0;
							pend_q     <= 1'b0;
							emit_cnt_q <= '0;
							state_q    <= S_SCAN;
						end
						OP_INSERT: begin
							if (CMPW'(pos_q) > CMPW'(count_q)) begin
								res_st_q <= ST_INVALID;
							end else if (count_q == DEPTH_C) begin
								res_st_q <= ST_FULL;
							end else begin
								idx_q   <= count_q;
								state_q <= S_SHUP_RD;
							end
						end
						OP_DEL_POS: begin
							if (CMPW'(pos_q) >= CMPW'(count_q)) begin
								res_st_q <= ST_INVALID;
							end else begin
								idx_q   <= CW'(pos_q);
								state_q <= S_SHDN_RD;
							end
						end
						default: begin
							res_st_q <= ST_INVALID;
						end
					endcase
				end
				S_SCAN: begin
					if (idx_q >= count_q) begin
						if (op_q == OP_SEARCH) begin
							state_q <= S_FINAL;
						end else begin
							res_st_q <= ST_NOT_FOUND;
							state_q  <= S_EMIT;
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (!match) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN;
					end else if (op_q == OP_DEL_VAL) begin
						state_q <= S_SHDN_RD;
					end else if (!pend_q) begin
						pend_q     <= 1'b1;
						pend_idx_q <= idx_q;
						idx_q      <= idx_q + CW'(1);
						state_q    <= S_SCAN;
					end else if (out_free) begin
						emit_cnt_q <= emit_cnt_q + 4'd1;
						pend_idx_q <= idx_q;
						idx_q      <= idx_q + CW'(1);
						// The held match is the last one allowed: close the search.
						state_q    <= (emit_cnt_q == LAST_PAIR) ? S_FINAL : S_SCAN;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SHDN_RD: begin
					if ((idx_q + CW'(1)) < count_q) begin
						state_q <= S_SHDN_WR;
					end else begin
						count_q  <= count_q - CW'(1);
						res_st_q <= ST_DONE;
						state_q  <= S_EMIT;
					end
				end
				S_SHDN_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_SHDN_RD;
				end
				S_SHUP_RD: begin
					if (CMPW'(idx_q) > CMPW'(pos_q)) begin
						state_q <= S_SHUP_WR;
					end else begin
						count_q  <= count_q + CW'(1);
						res_st_q <= ST_DONE;
						state_q  <= S_EMIT;
					end
				end
				S_SHUP_WR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SHUP_RD;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/oate_checker.sv =====
// ----------------------------------------------------------------------------
// oate_checker
// Port-level checks of the ordered array table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_array_table_engine_macros.svh"

module oate_checker import oate_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic             res_valid,
	input logic             res_ready,
	input status_t          status,
	input logic [IDX_W-1:0] match_index,
	input logic [CNT_W-1:0] fill_count,
	input logic             last
);

	// A stalled result word keeps its contents.
	`OATE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(status) && $stable(match_index) && $stable(fill_count) && $stable(last), "result word changed while stalled")

	// Only search matches can be followed by more words of the same command.
	`OATE_ASSERT_SAME(a_single_last, clk, arst_n, res_valid && status != ST_FOUND, last, "non-match result not marked last")

	`OATE_ASSERT_SAME(a_index_zero, clk, arst_n, res_valid && status != ST_FOUND, match_index == '0, "index set on a non-match result")

	// The engine works on one command at a time.
	`OATE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "ready held right after a command was taken")

endmodule

bind ordered_array_table_engine oate_checker u_oate_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.match_index (res.match_index),
	.fill_count  (res.fill_count),
	.last        (res.last)
);
